/* src/fev_pkg.sv */
`default_nettype none

package fev_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned CmdW    = 3;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CmdW-1:0] {
    CmdAdd      = 3'd0,
    CmdSub      = 3'd1,
    CmdMul      = 3'd2,
    CmdFma      = 3'd3,
    CmdScale    = 3'd4,
    CmdScaleAdd = 3'd5,
    CmdClamp    = 3'd6,
    CmdSanitize = 3'd7
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgScale    = 2'd0,
    CfgClampLo  = 2'd1,
    CfgClampHi  = 2'd2,
    CfgFallback = 2'd3
  } cfg_idx_e;

  localparam logic [DataW-1:0] QNan32  = 32'h7FC0_0000;
  localparam logic [DataW-1:0] Inf32   = 32'h7F80_0000;
  localparam logic [DataW-1:0] One32   = 32'h3F80_0000;
  localparam logic [DataW-1:0] NZero32 = 32'h8000_0000;
  localparam logic [DataW-1:0] NInf32  = 32'hFF80_0000;

  function automatic logic is_nan(input logic [DataW-1:0] u);
    return u[30:0] > Inf32[30:0];
  endfunction

  function automatic logic is_inf(input logic [DataW-1:0] u);
    return u[30:0] == Inf32[30:0];
  endfunction

  function automatic logic is_zero(input logic [DataW-1:0] u);
    return u[30:0] == 31'd0;
  endfunction

endpackage

`default_nettype wire

/* src/fev_if.sv */
`default_nettype none

interface fev_in_if;
  logic                         valid;
  logic                         ready;
  logic [fev_pkg::CmdW-1:0]     cmd;
  logic [fev_pkg::DataW-1:0]    operand_a;
  logic [fev_pkg::DataW-1:0]    operand_b;
  logic [fev_pkg::DataW-1:0]    operand_c;
  logic                         last_in;

  modport source (output valid, cmd, operand_a, operand_b, operand_c, last_in, input ready);
  modport sink   (input valid, cmd, operand_a, operand_b, operand_c, last_in, output ready);
endinterface

interface fev_out_if;
  logic                         valid;
  logic                         ready;
  logic [fev_pkg::DataW-1:0]    result_bits;
  logic                         replaced;
  logic                         last_out;

  modport source (output valid, result_bits, replaced, last_out, input ready);
  modport sink   (input valid, result_bits, replaced, last_out, output ready);
endinterface

interface fev_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [fev_pkg::CfgIdxW-1:0]  index;
  logic [fev_pkg::DataW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* src/fev_fma.sv */
`default_nettype none

// Eight-stage binary32 fused multiply-add, one rounding, RNE.
module fev_fma #(
  parameter int unsigned SideW = 1
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output      logic                      in_ready_o,
  input  wire logic [fev_pkg::DataW-1:0] a_i,
  input  wire logic [fev_pkg::DataW-1:0] b_i,
  input  wire logic [fev_pkg::DataW-1:0] c_i,
  input  wire logic [SideW-1:0]          side_i,
  output      logic                      out_valid_o,
  input  wire logic                      out_ready_i,
  output      logic [fev_pkg::DataW-1:0] res_o,
  output      logic [SideW-1:0]          side_o
);
  import fev_pkg::*;

  localparam int unsigned NStg = 8;
  localparam int unsigned ExpW = 11;

  typedef logic signed [ExpW-1:0] exp_t;

  function automatic logic [5:0] msb64(input logic [63:0] v);
    logic [5:0] r;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) r = i[5:0];
    end
    return r;
  endfunction

  // handshake: a stage loads when empty or when the next one moves
  logic [NStg-1:0] v_q;
  logic [NStg-1:0] en;

  always_comb begin
    en[NStg-1] = !v_q[NStg-1] || out_ready_i;
    for (int k = NStg - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NStg; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // sideband and special results ride along
  logic [SideW-1:0] side_q [NStg];
  logic             spv_q  [NStg];
  logic [DataW-1:0] spec_q [NStg];

  // stage 0: unpack, specials, significand product
  logic [7:0]  fa, fb, fc;
  logic [23:0] ma, mb, mc;
  exp_t        ea, eb, ec;
  logic        ps, cs, spv;
  logic [DataW-1:0] spec;

  always_comb begin
    fa = a_i[30:23];
    fb = b_i[30:23];
    fc = c_i[30:23];
    ma = {(fa != 8'd0), a_i[22:0]};
    mb = {(fb != 8'd0), b_i[22:0]};
    mc = {(fc != 8'd0), c_i[22:0]};
    ea = (fa == 8'd0) ? -exp_t'(149) : $signed({3'b0, fa}) - exp_t'(150);
    eb = (fb == 8'd0) ? -exp_t'(149) : $signed({3'b0, fb}) - exp_t'(150);
    ec = (fc == 8'd0) ? -exp_t'(149) : $signed({3'b0, fc}) - exp_t'(150);
    ps = a_i[31] ^ b_i[31];
    cs = c_i[31];
    spv  = 1'b1;
    spec = QNan32;
    if (is_nan(a_i) || is_nan(b_i) || is_nan(c_i)) begin
      spec = QNan32;
    end else if ((is_inf(a_i) && is_zero(b_i)) || (is_inf(b_i) && is_zero(a_i))) begin
      spec = QNan32;
    end else if (is_inf(a_i) || is_inf(b_i)) begin
      spec = (is_inf(c_i) && (cs != ps)) ? QNan32 : {ps, Inf32[30:0]};
    end else if (is_inf(c_i)) begin
      spec = c_i;
    end else if (is_zero(a_i) || is_zero(b_i)) begin
      if (is_zero(c_i)) spec = (ps == cs) ? c_i : '0;
      else              spec = c_i;
    end else begin
      spv = 1'b0;
    end
  end

  logic [47:0] prod_q0;
  exp_t        epr_q0, ec_q0;
  logic [23:0] mc_q0;
  logic        ps_q0, cs_q0, cz_q0;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      prod_q0   <= ma * mb;
      epr_q0    <= ea + eb;
      ec_q0     <= ec;
      mc_q0     <= mc;
      ps_q0     <= ps;
      cs_q0     <= cs;
      cz_q0     <= is_zero(c_i);
      side_q[0] <= side_i;
      spv_q[0]  <= spv;
      spec_q[0] <= spec;
    end
    for (int k = 1; k < NStg; k++) begin
      if (en[k]) begin
        side_q[k] <= side_q[k-1];
        spv_q[k]  <= spv_q[k-1];
        spec_q[k] <= spec_q[k-1];
      end
    end
  end

  // stage 1: leading-one positions
  logic [47:0] prod_q1;
  exp_t        epr_q1, ec_q1;
  logic [23:0] mc_q1;
  logic        ps_q1, cs_q1, cz_q1;
  logic [5:0]  dp_q1, dc_q1;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      prod_q1 <= prod_q0;
      epr_q1  <= epr_q0;
      ec_q1   <= ec_q0;
      mc_q1   <= mc_q0;
      ps_q1   <= ps_q0;
      cs_q1   <= cs_q0;
      cz_q1   <= cz_q0;
      dp_q1   <= msb64({16'b0, prod_q0});
      dc_q1   <= msb64({40'b0, mc_q0});
    end
  end

  // stage 2: normalize both to bit 61
  logic [5:0] shx, shy;
  logic [63:0] x_q2, y_q2;
  exp_t        ex_q2, ey_q2;
  logic        ps_q2, cs_q2, cz_q2;

  assign shx = 6'd61 - dp_q1;
  assign shy = 6'd61 - dc_q1;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      x_q2  <= {16'b0, prod_q1} << shx;
      y_q2  <= {40'b0, mc_q1} << shy;
      ex_q2 <= epr_q1 - $signed({5'b0, shx});
      ey_q2 <= ec_q1 - $signed({5'b0, shy});
      ps_q2 <= ps_q1;
      cs_q2 <= cs_q1;
      cz_q2 <= cz_q1;
    end
  end

  // stage 3: order by exponent, align smaller with sticky
  logic [63:0] xs, ys, ya;
  exp_t        exs, eys, dd;
  logic        sxs, sys, sya;

  always_comb begin
    if (!cz_q2 && (ex_q2 < ey_q2)) begin
      xs = y_q2; exs = ey_q2; sxs = cs_q2;
      ys = x_q2; eys = ex_q2; sys = ps_q2;
    end else begin
      xs = x_q2; exs = ex_q2; sxs = ps_q2;
      ys = y_q2; eys = ey_q2; sys = cs_q2;
    end
    dd  = exs - eys;
    sya = sys;
    if (cz_q2) begin
      ya  = '0;
      sya = sxs;
    end else if (dd >= exp_t'(63)) begin
      ya = 64'd1;
    end else if (dd > exp_t'(0)) begin
      ya = (ys >> dd[5:0]) |
           {63'b0, |(ys & ((64'd1 << dd[5:0]) - 64'd1))};
    end else begin
      ya = ys;
    end
  end

  logic [63:0] x_q3, y_q3;
  exp_t        e_q3;
  logic        sx_q3, sy_q3;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      x_q3  <= xs;
      y_q3  <= ya;
      e_q3  <= exs;
      sx_q3 <= sxs;
      sy_q3 <= sya;
    end
  end

  // stage 4: add or subtract magnitudes
  logic [63:0] sum;
  logic        sr;

  always_comb begin
    if (sx_q3 == sy_q3) begin
      sum = x_q3 + y_q3;
      sr  = sx_q3;
    end else if (x_q3 >= y_q3) begin
      sum = x_q3 - y_q3;
      sr  = sx_q3;
    end else begin
      sum = y_q3 - x_q3;
      sr  = sy_q3;
    end
  end

  logic [63:0] s_q4;
  exp_t        e_q4;
  logic        sr_q4;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s_q4  <= sum;
      e_q4  <= e_q3;
      sr_q4 <= sr;
    end
  end

  // stage 5: leading one of the sum, target exponent
  exp_t tgt;

  always_comb begin
    tgt = e_q4 + $signed({5'b0, msb64(s_q4)}) - exp_t'(23);
    if (tgt < -exp_t'(149)) tgt = -exp_t'(149);
  end

  logic [63:0] s_q5;
  exp_t        t_q5, sh_q5;
  logic        sr_q5, z_q5;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s_q5  <= s_q4;
      t_q5  <= tgt;
      sh_q5 <= tgt - e_q4;
      sr_q5 <= sr_q4;
      z_q5  <= (s_q4 == 64'd0);
    end
  end

  // stage 6: shift to 24 bits and round to nearest even
  logic [63:0] qf;
  logic [5:0]  shm1, nsh;
  logic        inc;
  exp_t        tb;

  always_comb begin
    shm1 = 6'(sh_q5 - exp_t'(1));
    nsh  = 6'(exp_t'(0) - sh_q5);
    inc  = 1'b0;
    if (sh_q5 > exp_t'(0)) begin
      if (sh_q5 >= exp_t'(64)) begin
        qf = '0;
      end else begin
        qf  = s_q5 >> sh_q5[5:0];
        inc = s_q5[shm1] && ((|(s_q5 & ((64'd1 << shm1) - 64'd1))) || qf[0]);
      end
    end else begin
      qf = s_q5 << nsh;
    end
    tb = t_q5 + exp_t'(149);
  end

  logic [24:0] q_q6;
  logic [7:0]  be_q6;
  logic        ovf_q6, sr_q6, z_q6;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      q_q6   <= qf[24:0] + {24'b0, inc};
      be_q6  <= tb[7:0];
      ovf_q6 <= tb > exp_t'(254);
      sr_q6  <= sr_q5;
      z_q6   <= z_q5;
    end
  end

  // stage 7: pack
  logic [DataW-1:0] bits, res;

  always_comb begin
    bits = {1'b0, be_q6, 23'b0} + {7'b0, q_q6};
    if (spv_q[6])                            res = spec_q[6];
    else if (z_q6)                           res = '0;
    else if (ovf_q6 || (bits >= Inf32))      res = {sr_q6, Inf32[30:0]};
    else                                     res = {sr_q6, bits[30:0]};
  end

  logic [DataW-1:0] res_q7;

  always_ff @(posedge clk_i) begin
    if (en[7]) res_q7 <= res;
  end

  assign res_o  = res_q7;
  assign side_o = side_q[NStg-1];

endmodule

`default_nettype wire

/* src/float_elementwise_vector_alu.sv */
`default_nettype none

// Channel   Dir  Payload                                      Handshake
// req_i     in   cmd, operand_a, operand_b, operand_c, last_in valid/ready
// rsp_o     out  result_bits, replaced, last_out              valid/ready
// cfg_i     in   index, data (scale, clamp lo/hi, fallback)   valid/ready, always ready
//
// One request per cycle while the output is not stalled; the path runs through
// two chained 8-stage FMA pipelines (scale_add rounds the product, then the sum, in the second).
// Reset (rst_ni low, async) empties both pipelines and loads the register
// defaults: scale 1.0, clamp -inf..+inf, fallback +0.
// Each stage holds while the one after it is full and stalled, so bubbles
// fill up under a stalled output and nothing is dropped or repeated.
module float_elementwise_vector_alu (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  fev_in_if.sink     req_i,
  fev_cfg_if.sink    cfg_i,
  fev_out_if.source  rsp_o
);
  import fev_pkg::*;

  // configuration registers
  logic [DataW-1:0] scale_q, clo_q, chi_q, fb_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= One32;
      clo_q   <= NInf32;
      chi_q   <= Inf32;
      fb_q    <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CfgScale:    scale_q <= cfg_i.data;
        CfgClampLo:  clo_q   <= cfg_i.data;
        CfgClampHi:  chi_q   <= cfg_i.data;
        CfgFallback: fb_q    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // IEEE ordering: NaN unordered, signed zeros equal
  function automatic logic [DataW-1:0] order_key(input logic [DataW-1:0] u);
    return u[31] ? ~u : (u | NZero32);
  endfunction

  function automatic logic less32(input logic [DataW-1:0] x, input logic [DataW-1:0] y);
    if (is_nan(x) || is_nan(y))   return 1'b0;
    if (is_zero(x) && is_zero(y)) return 1'b0;
    return order_key(x) < order_key(y);
  endfunction

  typedef struct packed {
    cmd_e             cmd;
    logic [DataW-1:0] b;
    logic [DataW-1:0] alt;
    logic             rep;
    logic             last;
  } side1_t;

  typedef struct packed {
    cmd_e             cmd;
    logic [DataW-1:0] r1;
    logic [DataW-1:0] alt;
    logic             rep;
    logic             last;
  } side2_t;

  cmd_e             cmd;
  logic [DataW-1:0] op_a, op_b, op_c, clamp_lo_r, alt;
  logic             rep;
  side1_t           s1_in, s1_out;
  side2_t           s2_in, s2_out;

  assign cmd = cmd_e'(req_i.cmd);

  // operand routing into the first FMA
  always_comb begin
    op_a = req_i.operand_a;
    op_b = One32;
    op_c = req_i.operand_b;
    case (cmd)
      CmdAdd: ;
      CmdSub:   op_c = req_i.operand_b ^ NZero32;
      CmdMul: begin
        op_b = req_i.operand_b;
        op_c = NZero32;
      end
      CmdFma: begin
        op_b = req_i.operand_b;
        op_c = req_i.operand_c;
      end
      CmdScale, CmdScaleAdd: begin
        op_a = scale_q;
        op_b = req_i.operand_a;
        op_c = NZero32;
      end
      default: ;
    endcase
  end

  // clamp and sanitize need no FMA; result rides the sideband
  always_comb begin
    clamp_lo_r = less32(req_i.operand_a, clo_q) ? clo_q : req_i.operand_a;
    alt = less32(chi_q, clamp_lo_r) ? chi_q : clamp_lo_r;
    rep = 1'b0;
    if (cmd == CmdSanitize) begin
      if (is_nan(req_i.operand_a) || is_inf(req_i.operand_a)) begin
        alt = fb_q;
        rep = 1'b1;
      end else begin
        alt = req_i.operand_a;
      end
    end
  end

  assign s1_in = '{cmd: cmd, b: req_i.operand_b, alt: alt, rep: rep, last: req_i.last_in};

  logic             u1_valid, u1_ready;
  logic [DataW-1:0] u1_res;

  fev_fma #(.SideW($bits(side1_t))) u_fma1 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .a_i         (op_a),
    .b_i         (op_b),
    .c_i         (op_c),
    .side_i      (s1_in),
    .out_valid_o (u1_valid),
    .out_ready_i (u1_ready),
    .res_o       (u1_res),
    .side_o      (s1_out)
  );

  // second pass: b + rounded product for scale_add
  assign s2_in = '{cmd: s1_out.cmd, r1: u1_res, alt: s1_out.alt, rep: s1_out.rep,
                   last: s1_out.last};

  logic [DataW-1:0] u2_res;

  fev_fma #(.SideW($bits(side2_t))) u_fma2 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (u1_valid),
    .in_ready_o  (u1_ready),
    .a_i         (s1_out.b),
    .b_i         (One32),
    .c_i         (u1_res),
    .side_i      (s2_in),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .res_o       (u2_res),
    .side_o      (s2_out)
  );

  always_comb begin
    case (s2_out.cmd)
      CmdScaleAdd:           rsp_o.result_bits = u2_res;
      CmdClamp, CmdSanitize: rsp_o.result_bits = s2_out.alt;
      default:               rsp_o.result_bits = s2_out.r1;
    endcase
  end

  assign rsp_o.replaced = s2_out.rep;
  assign rsp_o.last_out = s2_out.last;

endmodule

`default_nettype wire

/* verif/float_elementwise_vector_alu_test.sv */
`default_nettype none

module float_elementwise_vector_alu_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fev_pkg::*;

  // Pipeline depth of the two chained FMA units; drain waits use a margin on it.
  localparam int PipeDepth   = 16;
  localparam int CycleLimit  = 400000;
  localparam int PhaseItems  = 234;
  localparam int NumPhases   = 7;

  typedef struct {
    cmd_e        op;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic        last;
    logic        known;   // expected value typed in below
    logic [31:0] res;
    logic        rep;
  } element_row_t;

  typedef struct {
    logic [31:0] res;
    logic        rep;
    logic        last;
  } element_result_t;

  logic clk_i;
  logic rst_ni;

  fev_in_if  req ();
  fev_cfg_if cfg ();
  fev_out_if rsp ();

  float_elementwise_vector_alu dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .cfg_i  (cfg),
    .rsp_o  (rsp)
  );

  // Shadow copy of the register file, updated on every accepted write.
  logic [31:0] scale_reg, clamp_lo_reg, clamp_hi_reg, fallback_reg;

  element_result_t pending_results[$];
  int unsigned     error_count;
  int unsigned     cycle_count;
  logic            no_gaps;   // set for the stretch without any idling

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  //--------------------------------------------------------------------------
  // binary32 predictor: exact fused multiply-add with one rounding, RNE,
  // subnormals kept; add and mul are special cases of it.
  //--------------------------------------------------------------------------
  function automatic logic nan_bits(input logic [31:0] u);
    return u[30:0] > 31'h7F80_0000;
  endfunction

  function automatic logic inf_bits(input logic [31:0] u);
    return u[30:0] == 31'h7F80_0000;
  endfunction

  function automatic logic zero_bits(input logic [31:0] u);
    return u[30:0] == 31'd0;
  endfunction

  function automatic int msb64(input logic [63:0] v);
    int m;
    m = 0;
    for (int i = 0; i < 64; i++) if (v[i]) m = i;
    return m;
  endfunction

  function automatic void split_float(input logic [31:0] u, output logic [63:0] sig,
                                      output int ex);
    if (u[30:23] == 8'd0) begin
      sig = {41'd0, u[22:0]};
      ex  = -149;
    end else begin
      sig = {40'd0, 1'b1, u[22:0]};
      ex  = int'(u[30:23]) - 150;
    end
  endfunction

  // sign * s * 2^e, s nonzero, rounded to nearest even
  function automatic logic [31:0] round_to_single(input logic [31:0] sign,
                                                  input logic [63:0] s, input int e);
    int          m, target, sh;
    logic [63:0] q, rem, half, bits;
    m = msb64(s);
    target = e + m - 23;
    if (target < -149) target = -149;
    sh = target - e;
    if (sh > 0) begin
      if (sh >= 64) begin
        q = 64'd0;
      end else begin
        rem  = s & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        q    = s >> sh;
        if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      end
    end else begin
      q = (-sh >= 64) ? 64'd0 : (s << (-sh));
    end
    if (target + 149 > 254) return sign | Inf32;
    bits = (64'(target + 149) << 23) + q;
    if (bits >= 64'h7F80_0000) return sign | Inf32;
    return sign | bits[31:0];
  endfunction

  function automatic logic [31:0] fused_mul_add(input logic [31:0] a, input logic [31:0] b,
                                                input logic [31:0] c);
    logic [31:0] ps, cs, sx, sy, sr, ts;
    logic [63:0] ma, mb, mc, x, y, s, t;
    int          ea, eb, ec, ex, ey, d, te;
    ps = (a ^ b) & 32'h8000_0000;
    cs = c & 32'h8000_0000;
    if (nan_bits(a) || nan_bits(b) || nan_bits(c)) return QNan32;
    if ((inf_bits(a) && zero_bits(b)) || (inf_bits(b) && zero_bits(a))) return QNan32;
    if (inf_bits(a) || inf_bits(b)) begin
      if (inf_bits(c) && cs != ps) return QNan32;
      return ps | Inf32;
    end
    if (inf_bits(c)) return c;
    if (zero_bits(a) || zero_bits(b)) begin
      if (zero_bits(c)) return (ps == cs) ? c : 32'd0;
      return c;
    end
    split_float(a, ma, ea);
    split_float(b, mb, eb);
    x = ma * mb;
    d = msb64(x);
    x = x << (61 - d);
    ex = ea + eb - (61 - d);
    sx = ps;
    if (zero_bits(c)) return round_to_single(sx, x, ex);
    split_float(c, mc, ec);
    d = msb64(mc);
    y = mc << (61 - d);
    ey = ec - (61 - d);
    sy = cs;
    if (ex < ey) begin
      t = x; te = ex; ts = sx;
      x = y; ex = ey; sx = sy;
      y = t; ey = te; sy = ts;
    end
    d = ex - ey;
    // keep a sticky bit for anything shifted out
    if (d >= 63) y = 64'd1;
    else if (d > 0) y = (y >> d) | 64'((y & ((64'd1 << d) - 64'd1)) != 64'd0);
    if (sx == sy) begin
      s = x + y; sr = sx;
    end else if (x >= y) begin
      s = x - y; sr = sx;
    end else begin
      s = y - x; sr = sy;
    end
    if (s == 64'd0) return 32'd0;   // exact cancellation gives +0
    return round_to_single(sr, s, ex);
  endfunction

  function automatic logic [31:0] sum_single(input logic [31:0] a, input logic [31:0] b);
    return fused_mul_add(a, One32, b);
  endfunction

  function automatic logic [31:0] product_single(input logic [31:0] a, input logic [31:0] b);
    return fused_mul_add(a, b, NZero32);
  endfunction

  // total order on non-NaN values; -0 and +0 tie
  function automatic logic below(input logic [31:0] x, input logic [31:0] y);
    logic [31:0] kx, ky;
    if (nan_bits(x) || nan_bits(y)) return 1'b0;
    if (zero_bits(x) && zero_bits(y)) return 1'b0;
    kx = x[31] ? ~x : (x | 32'h8000_0000);
    ky = y[31] ? ~y : (y | 32'h8000_0000);
    return kx < ky;
  endfunction

  function automatic element_result_t predict_element(input cmd_e op, input logic [31:0] a,
                                                      input logic [31:0] b,
                                                      input logic [31:0] c,
                                                      input logic last);
    element_result_t r;
    r.rep  = 1'b0;
    r.last = last;
    case (op)
      CmdAdd:      r.res = sum_single(a, b);
      CmdSub:      r.res = sum_single(a, b ^ 32'h8000_0000);
      CmdMul:      r.res = product_single(a, b);
      CmdFma:      r.res = fused_mul_add(a, b, c);
      CmdScale:    r.res = product_single(scale_reg, a);
      CmdScaleAdd: r.res = sum_single(b, product_single(scale_reg, a));
      CmdClamp: begin
        // low bound first, then high wins
        r.res = a;
        if (below(r.res, clamp_lo_reg)) r.res = clamp_lo_reg;
        if (below(clamp_hi_reg, r.res)) r.res = clamp_hi_reg;
      end
      default: begin
        if (nan_bits(a) || inf_bits(a)) begin
          r.res = fallback_reg;
          r.rep = 1'b1;
        end else begin
          r.res = a;
        end
      end
    endcase
    return r;
  endfunction

  //--------------------------------------------------------------------------
  // Operand generator: specials, subnormals, raw patterns, mostly mid-range.
  //--------------------------------------------------------------------------
  function automatic logic [31:0] random_float();
    logic [31:0] specials[10];
    int unsigned sel;
    specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F7F_FFFF, 32'h0000_0001,
                 32'h3F80_0000, 32'h0080_0000};
    sel = $urandom_range(9);
    case (sel)
      0:       return $urandom;
      1:       return specials[$urandom_range(9)];
      2:       return {1'($urandom), 8'd0, 23'($urandom)};
      default: return {1'($urandom), 8'($urandom_range(154, 100)), 23'($urandom)};
    endcase
  endfunction

  //--------------------------------------------------------------------------
  // Directed rows. Expected values typed in only where they are obvious;
  // all run with the reset register values.
  //--------------------------------------------------------------------------
  element_row_t directed_rows[16] = '{
    '{CmdAdd,      32'h3F80_0000, 32'h3F80_0000, 32'h0,          1'b0, 1'b1, 32'h4000_0000, 1'b0},
    // invalid sum of opposite infinities
    '{CmdAdd,      32'h7F80_0000, 32'hFF80_0000, 32'h0,          1'b1, 1'b1, QNan32,        1'b0},
    // exact cancellation is +0
    '{CmdSub,      32'hC0A0_0000, 32'hC0A0_0000, 32'h0,          1'b0, 1'b1, 32'h0000_0000, 1'b0},
    '{CmdMul,      32'h0000_0000, 32'hFF80_0000, 32'h0,          1'b0, 1'b1, QNan32,        1'b0},
    // overflow to infinity
    '{CmdMul,      32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h0,          1'b1, 1'b1, Inf32,         1'b0},
    // half of the smallest subnormal ties to even, zero
    '{CmdMul,      32'h0000_0001, 32'h3F00_0000, 32'h0,          1'b0, 1'b1, 32'h0000_0000, 1'b0},
    '{CmdFma,      32'h3F80_0000, 32'h3F80_0000, 32'h7FC0_1234, 1'b0, 1'b1, QNan32,        1'b0},
    '{CmdFma,      32'h3FAA_AAAB, 32'h4040_0000, 32'hC080_0000, 1'b0, 1'b0, 32'h0,         1'b0},
    '{CmdFma,      32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, QNan32,        1'b0},
    '{CmdScale,    32'h4049_0FDB, 32'h0,          32'h0,          1'b0, 1'b1, 32'h4049_0FDB, 1'b0},
    '{CmdScaleAdd, 32'h3F80_0000, 32'hBF80_0000, 32'h0,          1'b0, 1'b1, 32'h0000_0000, 1'b0},
    // clamp lets NaN through with its payload
    '{CmdClamp,    32'hFFC0_0001, 32'h0,          32'h0,          1'b0, 1'b1, 32'hFFC0_0001, 1'b0},
    '{CmdClamp,    32'h8000_0000, 32'h0,          32'h0,          1'b1, 1'b1, 32'h8000_0000, 1'b0},
    '{CmdSanitize, 32'hFF80_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0000_0000, 1'b1},
    '{CmdSanitize, 32'h7F80_0001, 32'h0,          32'h0,          1'b0, 1'b1, 32'h0000_0000, 1'b1},
    '{CmdSanitize, 32'h7F7F_FFFF, 32'h0,          32'h0,          1'b1, 1'b1, 32'h7F7F_FFFF, 1'b0}
  };

  // Register settings per random phase: extremes first, the last ones random.
  logic [31:0] phase_regs[NumPhases][4] = '{
    '{32'h4000_0000, 32'hC000_0000, 32'h4040_0000, 32'h7FC0_0123},
    '{32'h7F80_0000, 32'h7FC0_0000, 32'hFF80_0000, 32'hFFFF_FFFF},
    // low bound above high bound
    '{32'h0000_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h7F80_0000},
    '{32'h0000_0001, 32'h8000_0000, 32'h0000_0000, 32'h7F7F_FFFF},
    '{32'hFFFF_FFFF, 32'hFF7F_FFFF, 32'h7F7F_FFFF, 32'h8000_0000},
    '{32'h0, 32'h0, 32'h0, 32'h0},
    '{32'h0, 32'h0, 32'h0, 32'h0}
  };

  //--------------------------------------------------------------------------
  // Request driver
  //--------------------------------------------------------------------------
  task automatic send_element(input element_row_t row);
    element_result_t r;
    if (!no_gaps) begin
      while ($urandom_range(99) < 32) begin
        req.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    req.valid     <= 1'b1;
    req.cmd       <= row.op;
    req.operand_a <= row.a;
    req.operand_b <= row.b;
    req.operand_c <= row.c;
    req.last_in   <= row.last;
    do @(posedge clk_i); while (!req.ready);
    // accepted at this edge; registers cannot change inside a phase
    r = predict_element(row.op, row.a, row.b, row.c, row.last);
    if (row.known) begin
      r.res = row.res;
      r.rep = row.rep;
    end
    pending_results.push_back(r);
  endtask

  // valid stays high between back-to-back writes; the caller drops it
  task automatic write_register(input cfg_idx_e idx, input logic [31:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk_i); while (!cfg.ready);
    case (idx)
      CfgScale:    scale_reg    = value;
      CfgClampLo:  clamp_lo_reg = value;
      CfgClampHi:  clamp_hi_reg = value;
      default:     fallback_reg = value;
    endcase
  endtask

  task automatic drain_pipeline();
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 4) @(posedge clk_i);
  endtask

  //--------------------------------------------------------------------------
  // Response checker and output stall generator
  //--------------------------------------------------------------------------
  always @(posedge clk_i) begin
    element_result_t want;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected response result=%h replaced=%b last=%b", $time,
                 rsp.result_bits, rsp.replaced, rsp.last_out);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (rsp.result_bits !== want.res) begin
          $display("%0t: result_bits expected %h actual %h", $time, want.res, rsp.result_bits);
          error_count++;
        end
        if (rsp.replaced !== want.rep) begin
          $display("%0t: replaced expected %b actual %b", $time, want.rep, rsp.replaced);
          error_count++;
        end
        if (rsp.last_out !== want.last) begin
          $display("%0t: last_out expected %b actual %b", $time, want.last, rsp.last_out);
          error_count++;
        end
      end
    end
    rsp.ready <= rst_ni && (no_gaps || $urandom_range(99) >= 32);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  //--------------------------------------------------------------------------
  // Main sequence
  //--------------------------------------------------------------------------
  initial begin
    element_row_t row;
    element_result_t guess;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    req.valid     = 1'b0;
    req.cmd       = CmdAdd;
    req.operand_a = '0;
    req.operand_b = '0;
    req.operand_c = '0;
    req.last_in   = 1'b0;
    cfg.valid     = 1'b0;
    cfg.index     = CfgScale;
    cfg.data      = '0;
    rsp.ready     = 1'b0;
    error_count   = 0;
    cycle_count   = 0;
    no_gaps       = 1'b0;
    scale_reg     = One32;
    clamp_lo_reg  = NInf32;
    clamp_hi_reg  = Inf32;
    fallback_reg  = 32'h0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) send_element(directed_rows[i]);
    drain_pipeline();

    for (int p = 0; p < NumPhases; p++) begin
      if (p >= NumPhases - 2) begin
        write_register(CfgScale,    random_float());
        write_register(CfgClampLo,  random_float());
        write_register(CfgClampHi,  random_float());
        write_register(CfgFallback, random_float());
      end else begin
        write_register(CfgScale,    phase_regs[p][0]);
        write_register(CfgClampLo,  phase_regs[p][1]);
        write_register(CfgClampHi,  phase_regs[p][2]);
        write_register(CfgFallback, phase_regs[p][3]);
      end
      cfg.valid <= 1'b0;
      // one phase runs back to back on both sides
      no_gaps = (p == 2);
      for (int n = 0; n < PhaseItems; n++) begin
        row.op    = cmd_e'($urandom_range(7));
        row.a     = random_float();
        row.b     = random_float();
        row.c     = random_float();
        row.last  = 1'($urandom);
        row.known = 1'b0;
        row.res   = '0;
        row.rep   = 1'b0;
        case ($urandom_range(7))
          0: row.b = row.a;                       // cancellation in sub
          1: row.b = row.a ^ 32'h8000_0000;       // cancellation in add
          2: begin                                // near-cancellation in fma
            guess = predict_element(CmdMul, row.a, row.b, row.c, 1'b0);
            row.c = (guess.res ^ 32'h8000_0000) + 32'($urandom_range(2)) - 32'd1;
          end
          default: ;
        endcase
        send_element(row);
      end
      drain_pipeline();
      no_gaps = 1'b0;
    end

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
src/fev_pkg.sv
src/fev_if.sv
src/fev_fma.sv
src/float_elementwise_vector_alu.sv
verif/float_elementwise_vector_alu_test.sv
